>>> sv/pdq_pkg.sv
// ----------------------------------------------------------------------------
// Priority dual queue package
// Shared sizes, command and status codes, and the server index helpers.
// ----------------------------------------------------------------------------
package pdq_pkg;

	localparam int INTAKE_DEPTH  = 16;
	localparam int QUEUE_DEPTH   = 16;
	localparam int HISTORY_DEPTH = 16;
	localparam int DOCTORS       = 5;

	localparam int MODE_W   = 2;
	localparam int ID_W     = 16;
	localparam int SRV_W    = 3;
	localparam int STATUS_W = 4;
	localparam int MOVED_W  = 5;
	localparam int LFSR_W   = 16;

	// Intake entries hold {urgent, id}; class and history entries hold {server, id}.
	localparam int INTAKE_W = ID_W + 1;
	localparam int QENT_W   = SRV_W + ID_W;

	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_RESET = 16'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD     = 2'd0,
		MODE_PROCESS = 2'd1,
		MODE_SERVE   = 2'd2,
		MODE_POP     = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED         = 4'd0,
		ST_INTAKE_FULL   = 4'd1,
		ST_ALL_MOVED     = 4'd2,
		ST_MOVED_PARTLY  = 4'd3,
		ST_SERVED_URGENT = 4'd4,
		ST_SERVED_ROUT   = 4'd5,
		ST_NONE_WAITING  = 4'd6,
		ST_HIST_SHOWN    = 4'd7,
		ST_HIST_EMPTY    = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PROCESS,
		BK_SERVE,
		BK_POP
	} back_state_t;

	typedef struct packed {
		mode_t             mode;
		logic [ID_W-1:0]   id;
		logic              urgent;
	} cmd_t;

	// Residues of every byte value, built at elaboration.
	typedef logic [255:0][SRV_W-1:0] mod_tab_t;

	function automatic mod_tab_t build_mod_tab();
		mod_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = SRV_W'(i % DOCTORS);
		end
		return t;
	endfunction

	localparam mod_tab_t MOD_TAB     = build_mod_tab();
	localparam int       BYTE_WEIGHT = 256 % DOCTORS;

	// Residue of a 16-bit value: fold the two bytes with the weight of the
	// high byte, the folded sum stays below one byte.
	function automatic logic [SRV_W-1:0] server_of(input logic [LFSR_W-1:0] v);
		logic [SRV_W-1:0] hi_mod;
		logic [SRV_W-1:0] lo_mod;
		logic [7:0]       folded;
		hi_mod = MOD_TAB[v[15:8]];
		lo_mod = MOD_TAB[v[7:0]];
		folded = 8'(hi_mod * BYTE_WEIGHT) + 8'(lo_mod);
		return MOD_TAB[folded];
	endfunction

	// One right shift of the Galois generator.
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] shifted;
		shifted = v >> 1;
		return v[0] ? (shifted ^ LFSR_TAPS) : shifted;
	endfunction

endpackage

>>> sv/pdq_req_if.sv
// ----------------------------------------------------------------------------
// Priority dual queue command channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface pdq_req_if;
	logic                       valid;
	logic                       ready;
	logic [pdq_pkg::MODE_W-1:0] mode;
	logic [pdq_pkg::ID_W-1:0]   patient_id;
	logic                       urgent;

	modport source (output valid, output mode, output patient_id, output urgent,
		input ready);
	modport sink (input valid, input mode, input patient_id, input urgent,
		output ready);
endinterface

>>> sv/pdq_rsp_if.sv
// ----------------------------------------------------------------------------
// Priority dual queue result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface pdq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pdq_pkg::STATUS_W-1:0] status;
	logic [pdq_pkg::ID_W-1:0]     entry_id;
	logic [pdq_pkg::SRV_W-1:0]    server_index;
	logic [pdq_pkg::MOVED_W-1:0]  moved_count;
	logic                         history_dropped;

	modport source (output valid, output status, output entry_id, output server_index,
		output moved_count, output history_dropped, input ready);
	modport sink (input valid, input status, input entry_id, input server_index,
		input moved_count, input history_dropped, output ready);
endinterface

>>> sv/pdq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/pdq_front.sv
// ----------------------------------------------------------------------------
// Priority dual queue front end
// Takes command words, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pdq_front (
	input  logic            clk,
	input  logic            arst_n,
	pdq_req_if.sink         req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output pdq_pkg::cmd_t   cmd
);

	pdq_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign req.ready = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{mode: pdq_pkg::mode_t'(req.mode), id: req.patient_id,
				urgent: req.urgent};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> sv/pdq_back.sv
// ----------------------------------------------------------------------------
// Priority dual queue back end
// Executes commands against the intake, class and history stores.
// ----------------------------------------------------------------------------
module pdq_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  pdq_pkg::cmd_t               cmd,
	input  logic                        cfg_we,
	input  logic [pdq_pkg::LFSR_W-1:0]  cfg_wdata,
	pdq_rsp_if.source                   rsp
);

	localparam int IA_W = $clog2(pdq_pkg::INTAKE_DEPTH);
	localparam int IC_W = $clog2(pdq_pkg::INTAKE_DEPTH + 1);
	localparam int QA_W = $clog2(pdq_pkg::QUEUE_DEPTH);
	localparam int QC_W = $clog2(pdq_pkg::QUEUE_DEPTH + 1);
	localparam int HA_W = $clog2(pdq_pkg::HISTORY_DEPTH);
	localparam int HC_W = $clog2(pdq_pkg::HISTORY_DEPTH + 1);

	localparam logic [IA_W-1:0] I_LAST = IA_W'(pdq_pkg::INTAKE_DEPTH - 1);
	localparam logic [QA_W-1:0] Q_LAST = QA_W'(pdq_pkg::QUEUE_DEPTH - 1);
	localparam logic [HA_W-1:0] H_LAST = HA_W'(pdq_pkg::HISTORY_DEPTH - 1);
	localparam logic [IC_W-1:0] I_FULL = IC_W'(pdq_pkg::INTAKE_DEPTH);
	localparam logic [QC_W-1:0] Q_FULL = QC_W'(pdq_pkg::QUEUE_DEPTH);
	localparam logic [HC_W-1:0] H_FULL = HC_W'(pdq_pkg::HISTORY_DEPTH);

	pdq_pkg::back_state_t state_q, state_d;

	logic [IA_W-1:0] ih_q, ih_d, it_q, it_d;
	logic [IC_W-1:0] ic_q, ic_d;
	logic [QA_W-1:0] uh_q, uh_d, ut_q, ut_d, rh_q, rh_d, rt_q, rt_d;
	logic [QC_W-1:0] uc_q, uc_d, rc_q, rc_d;
	logic [HA_W-1:0] ht_q, ht_d, ht_prev;
	logic [HC_W-1:0] hc_q, hc_d;
	logic [pdq_pkg::LFSR_W-1:0]  lfsr_q, lfsr_d, lfsr_adv;
	logic [pdq_pkg::MOVED_W-1:0] moved_q, moved_d;
	logic sel_urg_q, sel_urg_d;

	// Store ports.
	logic                          in_we;
	logic [pdq_pkg::INTAKE_W-1:0]  in_rdata;
	logic                          urg_we, rout_we, hist_we;
	logic [pdq_pkg::QENT_W-1:0]    q_wdata;
	logic [pdq_pkg::QENT_W-1:0]    urg_rdata, rout_rdata, hist_rdata, hist_wdata;

	// Result register.
	logic                          out_valid_q;
	pdq_pkg::status_t              out_status_q, res_status;
	logic [pdq_pkg::ID_W-1:0]      out_id_q, res_id;
	logic [pdq_pkg::SRV_W-1:0]     out_srv_q, res_srv;
	logic [pdq_pkg::MOVED_W-1:0]   out_moved_q, res_moved;
	logic                          out_drop_q, res_drop;
	logic                          res_load;
	logic                          out_free;

	logic                          head_urg;
	logic                          class_full;
	logic [pdq_pkg::SRV_W-1:0]     srv_new;
	logic [pdq_pkg::QENT_W-1:0]    served;

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd_ready = (state_q == pdq_pkg::BK_IDLE) && out_free;
	assign ht_prev   = (ht_q == '0) ? H_LAST : ht_q - 1'b1;

	assign head_urg   = in_rdata[pdq_pkg::ID_W];
	assign class_full = head_urg ? (uc_q == Q_FULL) : (rc_q == Q_FULL);
	assign lfsr_adv   = pdq_pkg::lfsr_step(lfsr_q);
	assign srv_new    = pdq_pkg::server_of(lfsr_adv);
	assign q_wdata    = {srv_new, in_rdata[pdq_pkg::ID_W-1:0]};
	assign served     = sel_urg_q ? urg_rdata : rout_rdata;
	assign hist_wdata = served;

	always_comb begin
		state_d    = state_q;
		ih_d       = ih_q;
		it_d       = it_q;
		ic_d       = ic_q;
		uh_d       = uh_q;
		ut_d       = ut_q;
		uc_d       = uc_q;
		rh_d       = rh_q;
		rt_d       = rt_q;
		rc_d       = rc_q;
		ht_d       = ht_q;
		hc_d       = hc_q;
		lfsr_d     = lfsr_q;
		moved_d    = moved_q;
		sel_urg_d  = sel_urg_q;
		in_we      = 1'b0;
		urg_we     = 1'b0;
		rout_we    = 1'b0;
		hist_we    = 1'b0;
		res_load   = 1'b0;
		res_status = pdq_pkg::ST_ADDED;
		res_id     = '0;
		res_srv    = '0;
		res_moved  = '0;
		res_drop   = 1'b0;

		unique case (state_q)
			pdq_pkg::BK_IDLE: begin
				if (cmd_valid && cmd_ready) begin
					unique case (cmd.mode)
						pdq_pkg::MODE_ADD: begin
							res_load = 1'b1;
							if (ic_q == I_FULL) begin
								res_status = pdq_pkg::ST_INTAKE_FULL;
							end else begin
								in_we      = 1'b1;
								it_d       = (it_q == I_LAST) ? '0 : it_q + 1'b1;
								ic_d       = ic_q + 1'b1;
								res_status = pdq_pkg::ST_ADDED;
							end
						end
						pdq_pkg::MODE_PROCESS: begin
							moved_d = '0;
							if (ic_q == '0) begin
								res_load   = 1'b1;
								res_status = pdq_pkg::ST_ALL_MOVED;
							end else begin
								state_d = pdq_pkg::BK_PROCESS;
							end
						end
						pdq_pkg::MODE_SERVE: begin
							if (uc_q == '0 && rc_q == '0) begin
								res_load   = 1'b1;
								res_status = pdq_pkg::ST_NONE_WAITING;
							end else begin
								sel_urg_d = (uc_q != '0);
								state_d   = pdq_pkg::BK_SERVE;
							end
						end
						pdq_pkg::MODE_POP: begin
							if (hc_q == '0) begin
								res_load   = 1'b1;
								res_status = pdq_pkg::ST_HIST_EMPTY;
							end else begin
								state_d = pdq_pkg::BK_POP;
							end
						end
						default: ;
					endcase
				end
			end
			pdq_pkg::BK_PROCESS: begin
				// The intake head word is on the read port this cycle.
				if (class_full) begin
					res_load   = 1'b1;
					res_status = pdq_pkg::ST_MOVED_PARTLY;
					res_moved  = moved_q;
					state_d    = pdq_pkg::BK_IDLE;
				end else begin
					lfsr_d  = lfsr_adv;
					moved_d = moved_q + 1'b1;
					ih_d    = (ih_q == I_LAST) ? '0 : ih_q + 1'b1;
					ic_d    = ic_q - 1'b1;
					if (head_urg) begin
						urg_we = 1'b1;
						ut_d   = (ut_q == Q_LAST) ? '0 : ut_q + 1'b1;
						uc_d   = uc_q + 1'b1;
					end else begin
						rout_we = 1'b1;
						rt_d    = (rt_q == Q_LAST) ? '0 : rt_q + 1'b1;
						rc_d    = rc_q + 1'b1;
					end
					if (ic_q == IC_W'(1)) begin
						res_load   = 1'b1;
						res_status = pdq_pkg::ST_ALL_MOVED;
						res_moved  = moved_q + 1'b1;
						state_d    = pdq_pkg::BK_IDLE;
					end
				end
			end
			pdq_pkg::BK_SERVE: begin
				if (sel_urg_q) begin
					uh_d       = (uh_q == Q_LAST) ? '0 : uh_q + 1'b1;
					uc_d       = uc_q - 1'b1;
					res_status = pdq_pkg::ST_SERVED_URGENT;
				end else begin
					rh_d       = (rh_q == Q_LAST) ? '0 : rh_q + 1'b1;
					rc_d       = rc_q - 1'b1;
					res_status = pdq_pkg::ST_SERVED_ROUT;
				end
				hist_we = 1'b1;
				ht_d    = (ht_q == H_LAST) ? '0 : ht_q + 1'b1;
				if (hc_q == H_FULL) begin
					res_drop = 1'b1;
				end else begin
					hc_d = hc_q + 1'b1;
				end
				res_load = 1'b1;
				res_id   = served[pdq_pkg::ID_W-1:0];
				res_srv  = served[pdq_pkg::QENT_W-1:pdq_pkg::ID_W];
				state_d  = pdq_pkg::BK_IDLE;
			end
			pdq_pkg::BK_POP: begin
				ht_d       = ht_prev;
				hc_d       = hc_q - 1'b1;
				res_load   = 1'b1;
				res_status = pdq_pkg::ST_HIST_SHOWN;
				res_id     = hist_rdata[pdq_pkg::ID_W-1:0];
				res_srv    = hist_rdata[pdq_pkg::QENT_W-1:pdq_pkg::ID_W];
				state_d    = pdq_pkg::BK_IDLE;
			end
			default: ;
		endcase
	end

	// The intake read address follows the next head, so a process run
	// fetches the following word while the current one is moved.
	pdq_ram #(.WIDTH(pdq_pkg::INTAKE_W), .DEPTH(pdq_pkg::INTAKE_DEPTH)) u_intake (
		.clk   (clk),
		.we    (in_we),
		.waddr (it_q),
		.wdata ({cmd.urgent, cmd.id}),
		.raddr (ih_d),
		.rdata (in_rdata)
	);

	pdq_ram #(.WIDTH(pdq_pkg::QENT_W), .DEPTH(pdq_pkg::QUEUE_DEPTH)) u_urgent (
		.clk   (clk),
		.we    (urg_we),
		.waddr (ut_q),
		.wdata (q_wdata),
		.raddr (uh_q),
		.rdata (urg_rdata)
	);

	pdq_ram #(.WIDTH(pdq_pkg::QENT_W), .DEPTH(pdq_pkg::QUEUE_DEPTH)) u_routine (
		.clk   (clk),
		.we    (rout_we),
		.waddr (rt_q),
		.wdata (q_wdata),
		.raddr (rh_q),
		.rdata (rout_rdata)
	);

	pdq_ram #(.WIDTH(pdq_pkg::QENT_W), .DEPTH(pdq_pkg::HISTORY_DEPTH)) u_history (
		.clk   (clk),
		.we    (hist_we),
		.waddr (ht_q),
		.wdata (hist_wdata),
		.raddr (ht_prev),
		.rdata (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pdq_pkg::BK_IDLE;
			ih_q      <= '0;
			it_q      <= '0;
			ic_q      <= '0;
			uh_q      <= '0;
			ut_q      <= '0;
			uc_q      <= '0;
			rh_q      <= '0;
			rt_q      <= '0;
			rc_q      <= '0;
			ht_q      <= '0;
			hc_q      <= '0;
			lfsr_q    <= pdq_pkg::LFSR_RESET;
			moved_q   <= '0;
			sel_urg_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ih_q      <= ih_d;
			it_q      <= it_d;
			ic_q      <= ic_d;
			uh_q      <= uh_d;
			ut_q      <= ut_d;
			uc_q      <= uc_d;
			rh_q      <= rh_d;
			rt_q      <= rt_d;
			rc_q      <= rc_d;
			ht_q      <= ht_d;
			hc_q      <= hc_d;
			moved_q   <= moved_d;
			sel_urg_q <= sel_urg_d;
			// A zero seed would lock the generator, so it loads as one.
			if (cfg_we) begin
				lfsr_q <= (cfg_wdata == '0) ? pdq_pkg::LFSR_RESET : cfg_wdata;
			end else begin
				lfsr_q <= lfsr_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_status_q <= res_status;
			out_id_q     <= res_id;
			out_srv_q    <= res_srv;
			out_moved_q  <= res_moved;
			out_drop_q   <= res_drop;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.entry_id        = out_id_q;
	assign rsp.server_index    = out_srv_q;
	assign rsp.moved_count     = out_moved_q;
	assign rsp.history_dropped = out_drop_q;

endmodule

>>> sv/priority_dual_queue_with_history_core.sv
// ----------------------------------------------------------------------------
// Priority dual queue with history
// Two-class strict-priority service queue with an intake FIFO and a bounded
// history stack.
// ----------------------------------------------------------------------------
// Add and refused or empty commands are answered straight from idle; serve and pop
// pass through their own state first, and process moves one intake entry per cycle
// until the intake is empty or the target class is full (partial moves too).
// The back end takes no new word until the last one has finished, and then only
// when the result register is free or being emptied.
// Reset clears pointers and counts and loads the generator with one; stores are not cleared.
module priority_dual_queue_with_history_core (
	input  logic                        clk,
	input  logic                        arst_n,
	pdq_req_if.sink                     req,
	pdq_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [pdq_pkg::LFSR_W-1:0]  cfg_wdata
);

	// The front end holds up to two decoded words, so new commands keep
	// arriving while the back end works through a long process run or while
	// a finished result waits for the consumer.
	logic          cmd_valid;
	logic          cmd_ready;
	pdq_pkg::cmd_t cmd;

	pdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// The back end owns the four stores, the generator and the result
	// register. It takes a new word only when idle and when the result
	// register is free or being emptied in the same cycle.
	pdq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule
